// ===== rtl/core/register_stack_machine_executor_assert.svh =====
// assertion macros for the stack machine executor
// used by the top level only, no other dependencies
`ifndef REGISTER_STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define REGISTER_STACK_MACHINE_EXECUTOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define RSME_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RSME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rsme_pkg.sv =====
// package for the stack machine executor: payload structs, codes, defaults
// no dependencies
package rsme_pkg;

  localparam int NUM_REGS_DEF     = 8;
  localparam int STACK_DEPTH_DEF  = 64;
  localparam int FRAME_DEPTH_DEF  = 16;
  localparam int NUM_SYSCALLS_DEF = 2;

  localparam logic [31:0] CHAR_LIMIT     = 32'd255;
  localparam logic [16:0] EXIT_PC_OFFSET = 17'd2;

  typedef enum logic [3:0] {
    OP_MOV = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_INC = 4'd3, OP_DEC = 4'd4,
    OP_PUSH = 4'd5, OP_POP = 4'd6, OP_CALL = 4'd7, OP_RET = 4'd8, OP_JMP = 4'd9,
    OP_JE = 4'd10, OP_CMP = 4'd11, OP_SYSCALL = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    E_OK = 3'd0, E_STACK_FULL = 3'd1, E_STACK_EMPTY = 3'd2, E_RANGE = 3'd3,
    E_SYSCALL = 3'd4, E_CHAR = 3'd5, E_FRAME_FULL = 3'd6
  } err_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [2:0]         dest_reg;
    logic               has_operand;
    logic               src_is_reg;
    logic [2:0]         src_reg;
    logic signed [31:0] immediate;
    logic signed [31:0] target;
  } in_item_t;

  typedef struct packed {
    logic [16:0] pc_out;
    logic [2:0]  error_code;
    logic        halted;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        equal_flag;
    logic        above_flag;
    logic        below_flag;
  } out_item_t;

  // instruction after classification in the front part
  typedef struct packed {
    in_item_t item;
    logic     tgt_ok;
  } dec_item_t;

endpackage

// ===== rtl/core/register_stack_machine_executor.sv =====
// Executes one decoded instruction per cycle while the output register is free
// or popped and no return is unwinding. An instruction enters a two-entry queue
// in the front part and is executed by the back part in the cycle it leaves the
// queue; its result is held in an output register. On its way it passes the
// queue entry, then the output register. The execute stage uses top-of-stack
// values cached in registers. A return that finds words pushed above its frame
// first cuts the data stack back before it executes.
// No clearing pass after reset.
module register_stack_machine_executor #(
  parameter int NUM_REGS     = rsme_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH  = rsme_pkg::STACK_DEPTH_DEF,
  parameter int FRAME_DEPTH  = rsme_pkg::FRAME_DEPTH_DEF,
  parameter int NUM_SYSCALLS = rsme_pkg::NUM_SYSCALLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  rsme_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output rsme_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import rsme_pkg::*;
  `include "register_stack_machine_executor_assert.svh"

  logic [15:0] prog_len_r;
  logic        dq_valid, dq_take;
  dec_item_t   dq_item;

  always_ff @(posedge clk) begin
    if (!rst_n) prog_len_r <= '0;
    else if (cfg_we) prog_len_r <= cfg_wdata;
  end

  rsme_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_item,
    .prog_len(prog_len_r), .dq_valid, .dq_item, .dq_take);

  rsme_back #(.NUM_REGS(NUM_REGS), .STACK_DEPTH(STACK_DEPTH),
              .FRAME_DEPTH(FRAME_DEPTH), .NUM_SYSCALLS(NUM_SYSCALLS)) u_back (
    .clk, .rst_n, .prog_len(prog_len_r), .dq_valid, .dq_item, .dq_take,
    .out_empty(empty), .out_pop(pop), .out_item);

  `RSME_ASSERT_IMP(a_take_valid, dq_take, dq_valid)
  `RSME_ASSERT_NEXT(a_take_result, dq_take, !empty)
  `RSME_ASSERT_IMP(a_halt_ok, !empty && out_item.halted && out_item.char_valid, 1'b0)
endmodule

// ===== rtl/core/rsme_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
module rsme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/rsme_front.sv =====
// front part: accepts instructions, checks jump range, feeds a two-entry queue
// depends on rsme_pkg
module rsme_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  rsme_pkg::in_item_t  in_item,
  input  logic [15:0]         prog_len,
  output logic                dq_valid,
  output rsme_pkg::dec_item_t dq_item,
  input  logic                dq_take
);
  import rsme_pkg::*;

  dec_item_t  q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push_ok, tgt_ok;

  assign in_full  = (cnt_r == 2'd2);
  assign push_ok  = in_push && !in_full;
  assign tgt_ok   = !in_item.target[31] && (in_item.target[30:0] <= {15'd0, prog_len});
  assign dq_valid = (cnt_r != 2'd0);
  assign dq_item  = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, dq_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wr_r <= !wr_r;
      if (dq_take) rd_r <= !rd_r;
    end
    if (push_ok) begin
      q_r[wr_r] <= '{item: in_item, tgt_ok: tgt_ok};
    end
  end
endmodule

// ===== rtl/core/rsme_back.sv =====
// back part: executes one instruction per cycle on registers, stacks and flags,
// unless the output or an unwind stalls; depends on rsme_pkg and rsme_ram
module rsme_back #(
  parameter int NUM_REGS     = rsme_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH  = rsme_pkg::STACK_DEPTH_DEF,
  parameter int FRAME_DEPTH  = rsme_pkg::FRAME_DEPTH_DEF,
  parameter int NUM_SYSCALLS = rsme_pkg::NUM_SYSCALLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         prog_len,
  input  logic                dq_valid,
  input  rsme_pkg::dec_item_t dq_item,
  output logic                dq_take,
  output logic                out_empty,
  input  logic                out_pop,
  output rsme_pkg::out_item_t out_item
);
  import rsme_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(FRAME_DEPTH);
  localparam int SDW = $clog2(STACK_DEPTH + 1);
  localparam int FDW = $clog2(FRAME_DEPTH + 1);
  localparam int RW = $clog2(NUM_REGS);

  logic [31:0]    regs_r [NUM_REGS];
  logic [SDW-1:0] sdep_r, sdep_nxt;
  logic [FDW-1:0] fdep_r, fdep_nxt;
  logic [2:0]     flags_r, flags_nxt; // eq, ab, be
  logic [16:0]    pc_r, pc_nxt, pc_w;
  logic           halt_r, halt_nxt;

  // top-of-stack caches: memories hold entries below the top
  logic [31:0]    stop_r, stop_nxt;
  logic [SDW-1:0] ftop_r, ftop_nxt;

  // second-from-top read data: ram output register, or the word written
  // into that slot at the same edge
  logic [31:0]    s_rd, s_top2, s_fwd_d_r;
  logic [SDW-1:0] f_rd, f_top2, f_fwd_d_r;
  logic           s_fwd_r, f_fwd_r;
  logic           s_we, f_we;
  logic [SW-1:0]  s_wa, s_ra;
  logic [FW-1:0]  f_wa, f_ra;
  logic [31:0]    s_wd;
  logic [SDW-1:0] f_wd;
  logic [SDW-1:0] s_dep_rd;

  // return with words above its frame: cut the stack back first
  logic           unwind, unwind_r;

  out_item_t o_r, o_nxt;
  logic      ov_r;

  in_item_t it;
  logic [31:0] dval, sval, ax, bx, sum, diff, wval;
  logic        wen, fire;
  logic [2:0]  err;
  logic        cv;
  logic [7:0]  cc;

  function automatic logic [31:0] rd(input logic [2:0] idx, input logic [31:0] r [NUM_REGS]);
    logic [31:0] v;
    v = '0;
    if (int'(idx) < NUM_REGS) v = r[RW'(idx)];
    return v;
  endfunction

  assign it       = dq_item.item;
  assign out_empty = !ov_r;
  assign out_item = o_r;
  assign unwind   = dq_valid && !halt_r && (it.op == OP_RET) && (fdep_r != '0) &&
                    (sdep_r > ftop_r);
  assign fire     = dq_valid && (!ov_r || out_pop) && !unwind;
  assign dq_take  = fire;
  assign s_top2   = s_fwd_r ? s_fwd_d_r : s_rd;
  assign f_top2   = f_fwd_r ? f_fwd_d_r : f_rd;

  always_comb begin
    dval = rd(it.dest_reg, regs_r);
    sval = it.src_is_reg ? rd(it.src_reg, regs_r) : it.immediate;
    ax   = regs_r[0];
    bx   = regs_r[1];
    sum  = dval + (it.op == OP_ADD ? sval : 32'd1);
    diff = dval - (it.op == OP_DEC ? 32'd1 : sval);
  end

  // execution
  always_comb begin
    sdep_nxt = sdep_r; fdep_nxt = fdep_r; flags_nxt = flags_r;
    halt_nxt = halt_r; stop_nxt = stop_r; ftop_nxt = ftop_r;
    pc_w = pc_r; err = E_OK; cv = 1'b0; cc = '0; wen = 1'b0; wval = '0;
    s_we = 1'b0; s_wa = '0; s_wd = stop_r; f_we = 1'b0; f_wa = '0; f_wd = ftop_r;
    if (!halt_r) begin
      case (it.op)
        OP_MOV: begin wen = 1'b1; wval = sval; end
        OP_ADD: begin wen = 1'b1; wval = sum; end
        OP_SUB: begin wen = 1'b1; wval = diff; end
        OP_INC: begin wen = it.has_operand; wval = sum; end
        OP_DEC: begin wen = it.has_operand; wval = diff; end
        OP_PUSH: begin
          if (sdep_r == SDW'(STACK_DEPTH)) err = E_STACK_FULL;
          else begin
            // spill old top into memory slot depth-1
            s_we = (sdep_r != '0); s_wa = SW'(sdep_r - 1'b1);
            stop_nxt = sval; sdep_nxt = sdep_r + 1'b1;
          end
        end
        OP_POP: begin
          if (sdep_r == '0) err = E_STACK_EMPTY;
          else begin
            wen = it.has_operand; wval = stop_r;
            stop_nxt = s_top2; sdep_nxt = sdep_r - 1'b1;
          end
        end
        OP_CALL: begin
          if (!dq_item.tgt_ok) err = E_RANGE;
          else if (sdep_r == SDW'(STACK_DEPTH)) err = E_STACK_FULL;
          else if (fdep_r == FDW'(FRAME_DEPTH)) err = E_FRAME_FULL;
          else begin
            s_we = (sdep_r != '0); s_wa = SW'(sdep_r - 1'b1);
            stop_nxt = {15'd0, pc_r}; sdep_nxt = sdep_r + 1'b1;
            f_we = (fdep_r != '0); f_wa = FW'(fdep_r - 1'b1);
            ftop_nxt = sdep_r + 1'b1; fdep_nxt = fdep_r + 1'b1;
            pc_w = it.target[16:0];
          end
        end
        OP_RET: begin
          if (fdep_r != '0) begin
            // stack is already cut back to the frame here
            if (sdep_r != '0) begin
              sdep_nxt = sdep_r - 1'b1; pc_w = stop_r[16:0]; stop_nxt = s_top2;
            end
            fdep_nxt = fdep_r - 1'b1; ftop_nxt = f_top2;
          end
        end
        OP_JMP: begin
          if (!dq_item.tgt_ok) err = E_RANGE; else pc_w = it.target[16:0];
        end
        OP_JE: begin
          if (!dq_item.tgt_ok) err = E_RANGE;
          else if (flags_r[0]) pc_w = it.target[16:0];
        end
        OP_CMP: begin
          if (diff == '0) flags_nxt = 3'b001;
          else if (diff[31]) flags_nxt = 3'b100;
          else flags_nxt = 3'b010;
        end
        OP_SYSCALL: begin
          if (ax >= 32'(NUM_SYSCALLS)) err = E_SYSCALL;
          else if (ax == 32'd0) begin
            pc_w = 17'(prog_len) + EXIT_PC_OFFSET; halt_nxt = 1'b1;
          end else if (ax == 32'd1) begin
            if (!bx[31] && bx > CHAR_LIMIT) err = E_CHAR;
            else begin cv = 1'b1; cc = bx[7:0]; end
          end
        end
        default: ;
      endcase
      pc_nxt = pc_w + 17'd1;
    end else begin
      pc_nxt = pc_r;
    end
    o_nxt = '{pc_out: pc_nxt, error_code: err, halted: halt_nxt, char_valid: cv,
              char_out: cc, equal_flag: flags_nxt[0], above_flag: flags_nxt[1],
              below_flag: flags_nxt[2]};
  end

  // read address tracks the entry just below the next top; an unwind first
  // fetches the frame's top entry, then the one below it
  assign s_dep_rd = fire ? sdep_nxt : ((unwind && unwind_r) ? ftop_r : sdep_r);
  assign s_ra = (unwind && !unwind_r) ? SW'(ftop_r - SDW'(1)) :
                (s_dep_rd >= SDW'(2) ? SW'(s_dep_rd - SDW'(2)) : '0);
  assign f_ra = (fire ? fdep_nxt : fdep_r) >= FDW'(2) ?
                FW'((fire ? fdep_nxt : fdep_r) - FDW'(2)) : '0;

  rsme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_sram (
    .clk, .we(s_we && fire), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  rsme_ram #(.WIDTH(SDW), .DEPTH(FRAME_DEPTH)) u_fram (
    .clk, .we(f_we && fire), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
      sdep_r <= '0; fdep_r <= '0; flags_r <= '0; pc_r <= '0; halt_r <= 1'b0;
      ov_r <= 1'b0; unwind_r <= 1'b0; s_fwd_r <= 1'b0; f_fwd_r <= 1'b0;
    end else begin
      unwind_r <= unwind && !unwind_r;
      s_fwd_r <= fire && s_we && (s_wa == s_ra);
      f_fwd_r <= fire && f_we && (f_wa == f_ra);
      if (unwind && unwind_r) sdep_r <= ftop_r;
      if (fire) begin
        if (wen && (int'(it.dest_reg) < NUM_REGS)) regs_r[RW'(it.dest_reg)] <= wval;
        sdep_r <= sdep_nxt; fdep_r <= fdep_nxt; flags_r <= flags_nxt;
        pc_r <= pc_nxt; halt_r <= halt_nxt;
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
    s_fwd_d_r <= s_wd;
    f_fwd_d_r <= f_wd;
    if (fire) begin
      o_r <= o_nxt; stop_r <= stop_nxt; ftop_r <= ftop_nxt;
    end else if (unwind && unwind_r) begin
      stop_r <= s_top2;
    end
  end
endmodule
